[rtl/core/tbo_pkg.sv]
// shared constants for the triangle box overlap test
// no dependencies
package tbo_pkg;
    localparam int unsigned VEC_LANES = 3;
endpackage

[rtl/core/triangle_box_overlap_test_top.sv]
// Triangle against axis-aligned box overlap, exact separating-axis test on
// doubled integer coordinates. Fully pipelined: one word accepted per cycle
// unless stalled, via prep, axis, edge, output registers; a stall freezes all
// stages together. Contact counts as overlap; an inverted box never overlaps.
// depends on tbo_pkg, tbo_prep, tbo_axes
module triangle_box_overlap_test_top
    import tbo_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [47:0] i_vertex_a,
    input  logic [47:0] i_vertex_b,
    input  logic [47:0] i_vertex_c,
    input  logic [47:0] i_box_min,
    input  logic [47:0] i_box_max,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_overlap
);
    localparam int CB = COORD_BITS;

    logic                 adv;
    logic [3:0]           r_vld;
    logic signed [CB+2:0] v [3][3];
    logic signed [CB+3:0] f [3][3];
    logic signed [CB+1:0] e [3];
    logic                 inv, ovl, r_ovl;

    assign adv     = ~(o_valid & i_stall);
    assign o_stall = ~adv;
    assign o_valid = r_vld[3];
    assign o_overlap = r_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ovl <= ovl;
        end
    end

    tbo_prep #(.CB(CB)) u_prep (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_va   (i_vertex_a[3*CB-1:0]),
        .i_vb   (i_vertex_b[3*CB-1:0]),
        .i_vc   (i_vertex_c[3*CB-1:0]),
        .i_bmin (i_box_min[3*CB-1:0]),
        .i_bmax (i_box_max[3*CB-1:0]),
        .o_v    (v),
        .o_f    (f),
        .o_e    (e),
        .o_inv  (inv)
    );

    tbo_axes #(.CB(CB)) u_axes (
        .i_clk  (i_clk),
        .i_en2  (adv),
        .i_en3  (adv),
        .i_v    (v),
        .i_f    (f),
        .i_e    (e),
        .i_inv  (inv),
        .o_ovl  (ovl)
    );
endmodule

[rtl/core/tbo_prep.sv]
// stage one: box translated to origin, doubled vertices, extents and edges
// depends on tbo_pkg
module tbo_prep
    import tbo_pkg::*;
#(
    parameter int CB = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [3*CB-1:0]             i_va,
    input  logic [3*CB-1:0]             i_vb,
    input  logic [3*CB-1:0]             i_vc,
    input  logic [3*CB-1:0]             i_bmin,
    input  logic [3*CB-1:0]             i_bmax,
    output logic signed [CB+2:0]        o_v [3][3],
    output logic signed [CB+3:0]        o_f [3][3],
    output logic signed [CB+1:0]        o_e [3],
    output logic                        o_inv
);
    logic signed [CB+2:0] n_v [3][3];
    logic signed [CB+3:0] n_f [3][3];
    logic signed [CB+1:0] n_e [3];
    logic                 n_inv;
    logic signed [CB-1:0] lo, hi;
    logic [3*CB-1:0]      w [3];

    always_comb begin
        w[0] = i_va;
        w[1] = i_vb;
        w[2] = i_vc;
        n_inv = 1'b0;
        for (int k = 0; k < VEC_LANES; k++) begin
            lo = $signed(i_bmin[k*CB +: CB]);
            hi = $signed(i_bmax[k*CB +: CB]);
            if (lo > hi) n_inv = 1'b1;
            n_e[k] = (CB+2)'(hi) - (CB+2)'(lo);
            for (int i = 0; i < 3; i++)
                n_v[i][k] = ((CB+3)'($signed(w[i][k*CB +: CB])) <<< 1)
                    - (CB+3)'(lo) - (CB+3)'(hi);
            n_f[0][k] = (CB+4)'(n_v[1][k]) - (CB+4)'(n_v[0][k]);
            n_f[1][k] = (CB+4)'(n_v[2][k]) - (CB+4)'(n_v[1][k]);
            n_f[2][k] = (CB+4)'(n_v[0][k]) - (CB+4)'(n_v[2][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v   <= n_v;
            o_f   <= n_f;
            o_e   <= n_e;
            o_inv <= n_inv;
        end
    end
endmodule

[rtl/core/tbo_axes.sv]
// stages two and three: axis products, normal, partial sums, final compare
// depends on tbo_pkg
module tbo_axes
    import tbo_pkg::*;
#(
    parameter int CB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en2,
    input  logic                 i_en3,
    input  logic signed [CB+2:0] i_v [3][3],
    input  logic signed [CB+3:0] i_f [3][3],
    input  logic signed [CB+1:0] i_e [3],
    input  logic                 i_inv,
    output logic                 o_ovl
);
    localparam int PW = 2*CB+9;
    localparam int NW = 2*CB+9;
    localparam int SW = 3*CB+14;

    // stage two: per-axis projections, radii, face test and normal
    logic signed [PW-1:0] n_p [9][3];
    logic signed [PW-1:0] n_r [9];
    logic                 n_face;
    logic signed [NW-1:0] n_n [3];
    logic signed [PW-1:0] r_p [9][3];
    logic signed [PW-1:0] r_r [9];
    logic                 r_face, r_inv;
    logic signed [NW-1:0] r_n [3];
    logic signed [CB+2:0] r_v0 [3];
    logic signed [CB+1:0] r_e [3];
    logic signed [CB+3:0] a [3];
    logic signed [CB+3:0] fa;
    logic signed [CB+2:0] mn, mx;

    always_comb begin
        n_face = 1'b1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                a[0] = '0; a[1] = '0; a[2] = '0;
                case (i)
                    0: begin a[1] = -i_f[j][2]; a[2] = i_f[j][1]; end
                    1: begin a[0] = i_f[j][2]; a[2] = -i_f[j][0]; end
                    default: begin a[0] = -i_f[j][1]; a[1] = i_f[j][0]; end
                endcase
                n_r[i*3+j] = '0;
                for (int k = 0; k < 3; k++) begin
                    fa = (a[k] < 0) ? -a[k] : a[k];
                    n_r[i*3+j] = n_r[i*3+j] + PW'(i_e[k]) * PW'(fa);
                end
                for (int t = 0; t < 3; t++) begin
                    n_p[i*3+j][t] = '0;
                    for (int k = 0; k < 3; k++)
                        n_p[i*3+j][t] = n_p[i*3+j][t] + PW'(a[k]) * PW'(i_v[t][k]);
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            mn = i_v[0][k]; mx = i_v[0][k];
            for (int t = 1; t < 3; t++) begin
                if (i_v[t][k] < mn) mn = i_v[t][k];
                if (i_v[t][k] > mx) mx = i_v[t][k];
            end
            if ((CB+3)'(mx) < -(CB+3)'(i_e[k]) || mn > (CB+3)'(i_e[k])) n_face = 1'b0;
        end
        n_n[0] = NW'(i_f[0][1])*NW'(i_f[1][2]) - NW'(i_f[0][2])*NW'(i_f[1][1]);
        n_n[1] = NW'(i_f[0][2])*NW'(i_f[1][0]) - NW'(i_f[0][0])*NW'(i_f[1][2]);
        n_n[2] = NW'(i_f[0][0])*NW'(i_f[1][1]) - NW'(i_f[0][1])*NW'(i_f[1][0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_p    <= n_p;
            r_r    <= n_r;
            r_face <= n_face;
            r_inv  <= i_inv;
            r_n    <= n_n;
            r_v0   <= i_v[0];
            r_e    <= i_e;
        end
    end

    // stage three: edge axis checks and plane products
    logic                 n_edge;
    logic signed [SW-1:0] n_s, n_pr;
    logic signed [PW-1:0] pmin, pmax;
    logic signed [NW-1:0] an;
    logic                 r_edge, r_ok;
    logic signed [SW-1:0] r_s, r_pr;

    always_comb begin
        n_edge = 1'b1;
        for (int x = 0; x < 9; x++) begin
            pmin = r_p[x][0]; pmax = r_p[x][0];
            for (int t = 1; t < 3; t++) begin
                if (r_p[x][t] < pmin) pmin = r_p[x][t];
                if (r_p[x][t] > pmax) pmax = r_p[x][t];
            end
            if (pmin > r_r[x] || -pmax > r_r[x]) n_edge = 1'b0;
        end
        n_s  = '0;
        n_pr = '0;
        for (int k = 0; k < 3; k++) begin
            an   = (r_n[k] < 0) ? -r_n[k] : r_n[k];
            n_s  = n_s + SW'(r_n[k]) * SW'(r_v0[k]);
            n_pr = n_pr + SW'(an) * SW'(r_e[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_edge <= n_edge;
            r_ok   <= r_face & ~r_inv;
            r_s    <= n_s;
            r_pr   <= n_pr;
        end
    end

    // stage four compare, registered by the top
    logic signed [SW-1:0] sa;
    always_comb begin
        sa    = (r_s < 0) ? -r_s : r_s;
        o_ovl = r_edge & r_ok & (sa <= r_pr);
    end
endmodule

[rtl/core/tbo_checker.sv]
// port-level checks for the overlap pipeline
// depends on triangle_box_overlap_test_top
module tbo_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_overlap
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_overlap))
        else $error("stalled word changed");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall without full output");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 (!o_stall) [*3] |=> o_valid)
        else $error("word lost in pipeline");
endmodule

bind triangle_box_overlap_test_top tbo_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_overlap(o_overlap)
);
